FILE: hdl/bpeo_pkg.sv
// Package for the bipartite edge orientation block.
// Holds field widths, status codes, datapath operation codes and the
// controller/datapath interface structs. Depends on nothing.
`default_nettype none

package bpeo_pkg;

    localparam int NODE_W        = 11;
    localparam int STATUS_W      = 2;
    localparam int WORD_BITS     = 64;
    localparam int BITCNT_W      = 7;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 2048;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd2;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ODD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_LOAD   = 5'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 5'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 5'd2;
    localparam logic [OP_W-1:0] OP_E_RD   = 5'd3;
    localparam logic [OP_W-1:0] OP_E_A    = 5'd4;
    localparam logic [OP_W-1:0] OP_E_AW   = 5'd5;
    localparam logic [OP_W-1:0] OP_E_B    = 5'd6;
    localparam logic [OP_W-1:0] OP_E_BW   = 5'd7;
    localparam logic [OP_W-1:0] OP_PFX_RD = 5'd8;
    localparam logic [OP_W-1:0] OP_PFX_WR = 5'd9;
    localparam logic [OP_W-1:0] OP_W_INIT = 5'd10;
    localparam logic [OP_W-1:0] OP_W_POP  = 5'd11;
    localparam logic [OP_W-1:0] OP_W_U    = 5'd12;
    localparam logic [OP_W-1:0] OP_W_LO   = 5'd13;
    localparam logic [OP_W-1:0] OP_W_HI   = 5'd14;
    localparam logic [OP_W-1:0] OP_W_UC   = 5'd15;
    localparam logic [OP_W-1:0] OP_W_NB   = 5'd16;
    localparam logic [OP_W-1:0] OP_W_V    = 5'd17;
    localparam logic [OP_W-1:0] OP_W_VS   = 5'd18;
    localparam logic [OP_W-1:0] OP_O_RD   = 5'd19;
    localparam logic [OP_W-1:0] OP_O_A    = 5'd20;
    localparam logic [OP_W-1:0] OP_O_BIT  = 5'd21;
    localparam logic [OP_W-1:0] OP_OUT    = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fill;
        logic            take;
        logic            give;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic clr_end;
        logic pfx_end;
        logic ei_last;
        logic sp_zero;
        logic k_end;
        logic v_clash;
        logic word_end;
        logic out_last;
    } stat_t;

endpackage

`default_nettype wire

FILE: hdl/bpeo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module bpeo_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  wire logic [W-1:0]                  wdata,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic      [W-1:0]                  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/bpeo_datapath.sv
// Datapath: edge, neighbour, list-start, node-state and stack memories with
// their counters, plus the node count register and result registers.
// Depends on bpeo_pkg and bpeo_ram.
`default_nettype none

module bpeo_datapath #(
    parameter int MAX_NODES = bpeo_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = bpeo_pkg::DEF_MAX_EDGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bpeo_pkg::cmd_t                  cmd,
    output bpeo_pkg::stat_t                      stat,
    input  wire logic                            cfg_wen,
    input  wire logic [bpeo_pkg::NODE_W-1:0]     cfg_wdata,
    input  wire logic [bpeo_pkg::NODE_W-1:0]     in_first,
    input  wire logic [bpeo_pkg::NODE_W-1:0]     in_second,
    output logic      [bpeo_pkg::STATUS_W-1:0]   out_status,
    output logic      [bpeo_pkg::WORD_BITS-1:0]  out_bits,
    output logic      [bpeo_pkg::BITCNT_W-1:0]   out_count,
    output logic                                 out_last
);

    localparam int NW   = bpeo_pkg::NODE_W;
    localparam int ND   = MAX_NODES + 2;
    localparam int NAW  = $clog2(ND);
    localparam int NCW  = ($clog2(MAX_NODES + 2) > NW) ? $clog2(MAX_NODES + 2) : NW;
    localparam int ETW  = $clog2(MAX_EDGES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW   = $clog2(2 * MAX_EDGES + 1);
    localparam int NBA  = $clog2(2 * MAX_EDGES);
    localparam int SPW  = $clog2(MAX_NODES + 1);
    localparam int SKA  = $clog2(MAX_NODES);

    logic [NW-1:0]  node_count_reg;
    logic [ETW-1:0] total_reg;
    logic           err_reg;
    logic [ETW-1:0] ei_reg;
    logic [NAW-1:0] ni_reg;
    logic [SW-1:0]  acc_reg;
    logic [NW-1:0]  a_reg;
    logic [NW-1:0]  b_reg;
    logic [NAW-1:0] u_reg;
    logic [SW-1:0]  k_reg;
    logic [SW-1:0]  hi_reg;
    logic           ucol_reg;
    logic [NAW-1:0] v_reg;
    logic [SPW-1:0] sp_reg;
    logic [bpeo_pkg::STATUS_W-1:0]  status_reg;
    logic [bpeo_pkg::WORD_BITS-1:0] bits_reg;
    logic [bpeo_pkg::BITCNT_W-1:0]  count_reg;
    logic                           last_reg;

    logic [NCW-1:0] n_eff;
    logic           in_ok;
    logic           ei_last;
    logic           v_clash;

    logic             edge_we;
    logic [EAW-1:0]   edge_wa;
    logic [EAW-1:0]   edge_ra;
    logic [2*NW-1:0]  edge_wd;
    logic [2*NW-1:0]  edge_rd;
    logic             start_we;
    logic [NAW-1:0]   start_wa;
    logic [NAW-1:0]   start_ra;
    logic [SW-1:0]    start_wd;
    logic [SW-1:0]    start_rd;
    logic             nb_we;
    logic [NBA-1:0]   nb_wa;
    logic [NBA-1:0]   nb_ra;
    logic [NW-1:0]    nb_wd;
    logic [NW-1:0]    nb_rd;
    logic             ns_we;
    logic [NAW-1:0]   ns_wa;
    logic [NAW-1:0]   ns_ra;
    logic [1:0]       ns_wd;
    logic [1:0]       ns_rd;
    logic             stk_we;
    logic [SKA-1:0]   stk_wa;
    logic [SKA-1:0]   stk_ra;
    logic [NAW-1:0]   stk_wd;
    logic [NAW-1:0]   stk_rd;

    logic [NAW-1:0] edge_a;
    logic [NAW-1:0] idx_a;
    logic [NAW-1:0] idx_b;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCW'(1);
        end
        else if (NCW'(node_count_reg) > NCW'(MAX_NODES))
        begin
            n_eff = NCW'(MAX_NODES);
        end
        else
        begin
            n_eff = NCW'(node_count_reg);
        end
    end

    assign in_ok = (in_first != '0) && (NCW'(in_first) <= n_eff)
                && (in_second != '0) && (NCW'(in_second) <= n_eff)
                && (total_reg != ETW'(MAX_EDGES));
    assign ei_last = ((ei_reg + ETW'(1)) == total_reg);
    assign v_clash = ns_rd[1] && (ns_rd[0] == ucol_reg);

    assign edge_a = NAW'(edge_rd[NW-1:0]);
    assign idx_a  = cmd.fill ? NAW'(a_reg) : NAW'(a_reg) + NAW'(1);
    assign idx_b  = cmd.fill ? NAW'(b_reg) : NAW'(b_reg) + NAW'(1);

    always_comb
    begin
        edge_we  = 1'b0;
        edge_wa  = total_reg[EAW-1:0];
        edge_wd  = {in_second, in_first};
        edge_ra  = ei_reg[EAW-1:0];
        start_we = 1'b0;
        start_wa = ni_reg;
        start_wd = '0;
        start_ra = ni_reg;
        nb_we    = 1'b0;
        nb_wa    = NBA'(start_rd);
        nb_wd    = b_reg;
        nb_ra    = NBA'(k_reg);
        ns_we    = 1'b0;
        ns_wa    = ni_reg;
        ns_wd    = 2'b00;
        ns_ra    = u_reg;
        stk_we   = 1'b0;
        stk_wa   = SKA'(sp_reg);
        stk_wd   = v_reg;
        stk_ra   = SKA'(sp_reg - SPW'(1));
        unique case (cmd.op)
            bpeo_pkg::OP_LOAD:
            begin
                edge_we = cmd.take && in_ok;
            end
            bpeo_pkg::OP_CLEAR:
            begin
                start_we = 1'b1;
                ns_we    = 1'b1;
            end
            bpeo_pkg::OP_E_A:
            begin
                start_ra = cmd.fill ? edge_a : edge_a + NAW'(1);
            end
            bpeo_pkg::OP_E_AW:
            begin
                start_we = 1'b1;
                start_wa = idx_a;
                start_wd = start_rd + SW'(1);
                nb_we    = cmd.fill;
                nb_wd    = b_reg;
            end
            bpeo_pkg::OP_E_B:
            begin
                start_ra = idx_b;
            end
            bpeo_pkg::OP_E_BW:
            begin
                start_we = 1'b1;
                start_wa = idx_b;
                start_wd = start_rd + SW'(1);
                nb_we    = cmd.fill;
                nb_wd    = a_reg;
            end
            bpeo_pkg::OP_PFX_WR:
            begin
                start_we = 1'b1;
                start_wd = acc_reg + start_rd;
            end
            bpeo_pkg::OP_W_INIT:
            begin
                ns_we  = 1'b1;
                ns_wa  = NAW'(1);
                ns_wd  = 2'b11;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = NAW'(1);
            end
            bpeo_pkg::OP_W_U:
            begin
                start_ra = stk_rd - NAW'(1);
            end
            bpeo_pkg::OP_W_LO:
            begin
                start_ra = u_reg;
            end
            bpeo_pkg::OP_W_V:
            begin
                ns_ra = NAW'(nb_rd);
            end
            bpeo_pkg::OP_W_VS:
            begin
                ns_we  = !ns_rd[1];
                ns_wa  = v_reg;
                ns_wd  = {1'b1, !ucol_reg};
                stk_we = !ns_rd[1];
            end
            bpeo_pkg::OP_O_A:
            begin
                ns_ra = edge_a;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= bpeo_pkg::NODE_COUNT_RST;
            total_reg      <= '0;
            err_reg        <= 1'b0;
            ei_reg         <= '0;
            ni_reg         <= '0;
            acc_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            u_reg          <= '0;
            k_reg          <= '0;
            hi_reg         <= '0;
            ucol_reg       <= 1'b0;
            v_reg          <= '0;
            sp_reg         <= '0;
            status_reg     <= bpeo_pkg::ST_OK;
            bits_reg       <= '0;
            count_reg      <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                node_count_reg <= cfg_wdata;
            end
            unique case (cmd.op)
                bpeo_pkg::OP_LOAD:
                begin
                    if (cmd.take)
                    begin
                        if (in_ok)
                        begin
                            total_reg <= total_reg + ETW'(1);
                        end
                        else
                        begin
                            err_reg <= 1'b1;
                        end
                    end
                end
                bpeo_pkg::OP_CHECK:
                begin
                    ni_reg <= '0;
                    ei_reg <= '0;
                    if (err_reg)
                    begin
                        status_reg <= bpeo_pkg::ST_ERR;
                        bits_reg   <= '0;
                        count_reg  <= '0;
                        last_reg   <= 1'b1;
                    end
                end
                bpeo_pkg::OP_CLEAR:
                begin
                    ni_reg <= ni_reg + NAW'(1);
                end
                bpeo_pkg::OP_E_A:
                begin
                    a_reg <= edge_rd[NW-1:0];
                    b_reg <= edge_rd[2*NW-1:NW];
                end
                bpeo_pkg::OP_E_BW:
                begin
                    if (ei_last)
                    begin
                        ei_reg  <= '0;
                        ni_reg  <= '0;
                        acc_reg <= '0;
                    end
                    else
                    begin
                        ei_reg <= ei_reg + ETW'(1);
                    end
                end
                bpeo_pkg::OP_PFX_WR:
                begin
                    acc_reg <= acc_reg + start_rd;
                    ni_reg  <= ni_reg + NAW'(1);
                end
                bpeo_pkg::OP_W_INIT:
                begin
                    sp_reg <= SPW'(1);
                end
                bpeo_pkg::OP_W_POP:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_reg - SPW'(1);
                    end
                    else
                    begin
                        ei_reg     <= '0;
                        status_reg <= bpeo_pkg::ST_OK;
                        bits_reg   <= '0;
                        count_reg  <= '0;
                        last_reg   <= 1'b0;
                    end
                end
                bpeo_pkg::OP_W_U:
                begin
                    u_reg <= stk_rd;
                end
                bpeo_pkg::OP_W_LO:
                begin
                    k_reg <= start_rd;
                end
                bpeo_pkg::OP_W_HI:
                begin
                    hi_reg <= start_rd;
                end
                bpeo_pkg::OP_W_UC:
                begin
                    ucol_reg <= ns_rd[0];
                end
                bpeo_pkg::OP_W_V:
                begin
                    v_reg <= NAW'(nb_rd);
                end
                bpeo_pkg::OP_W_VS:
                begin
                    k_reg <= k_reg + SW'(1);
                    if (v_clash)
                    begin
                        status_reg <= bpeo_pkg::ST_ODD;
                        bits_reg   <= '0;
                        count_reg  <= '0;
                        last_reg   <= 1'b1;
                    end
                    else if (!ns_rd[1])
                    begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                end
                bpeo_pkg::OP_O_BIT:
                begin
                    bits_reg[count_reg[5:0]] <= ns_rd[0];
                    count_reg <= count_reg + 7'd1;
                    ei_reg    <= ei_reg + ETW'(1);
                    last_reg  <= ei_last;
                end
                bpeo_pkg::OP_OUT:
                begin
                    if (cmd.give)
                    begin
                        bits_reg  <= '0;
                        count_reg <= '0;
                        if (last_reg)
                        begin
                            total_reg <= '0;
                            err_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.err      = err_reg;
    assign stat.clr_end  = (NCW'(ni_reg) == (n_eff + NCW'(1)));
    assign stat.pfx_end  = (NCW'(ni_reg) == n_eff);
    assign stat.ei_last  = ei_last;
    assign stat.sp_zero  = (sp_reg == '0);
    assign stat.k_end    = (k_reg == hi_reg);
    assign stat.v_clash  = v_clash;
    assign stat.word_end = (count_reg == 7'(bpeo_pkg::WORD_BITS - 1)) || ei_last;
    assign stat.out_last = last_reg;

    assign out_status = status_reg;
    assign out_bits   = bits_reg;
    assign out_count  = count_reg;
    assign out_last   = last_reg;

    bpeo_ram #(.W(2 * NW), .D(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_wa),
        .wdata (edge_wd),
        .raddr (edge_ra),
        .rdata (edge_rd)
    );

    bpeo_ram #(.W(SW), .D(ND)) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (start_wa),
        .wdata (start_wd),
        .raddr (start_ra),
        .rdata (start_rd)
    );

    bpeo_ram #(.W(NW), .D(2 * MAX_EDGES)) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_wa),
        .wdata (nb_wd),
        .raddr (nb_ra),
        .rdata (nb_rd)
    );

    bpeo_ram #(.W(2), .D(ND)) u_node_ram (
        .clk   (clk),
        .we    (ns_we),
        .waddr (ns_wa),
        .wdata (ns_wd),
        .raddr (ns_ra),
        .rdata (ns_rd)
    );

    bpeo_ram #(.W(NAW), .D(MAX_NODES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_wa),
        .wdata (stk_wd),
        .raddr (stk_ra),
        .rdata (stk_rd)
    );

endmodule

`default_nettype wire

FILE: hdl/bpeo_ctrl.sv
// Controller state machine: sequences loading, list building, the
// depth-first walk and result output. Depends on bpeo_pkg.
`default_nettype none

module bpeo_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_tvalid,
    input  wire logic             in_last,
    output logic                  in_tready,
    output logic                  out_tvalid,
    input  wire logic             out_tready,
    input  wire bpeo_pkg::stat_t  stat,
    output bpeo_pkg::cmd_t        cmd
);

    localparam logic [bpeo_pkg::OP_W-1:0] S_LOAD   = bpeo_pkg::OP_LOAD;
    localparam logic [bpeo_pkg::OP_W-1:0] S_CHECK  = bpeo_pkg::OP_CHECK;
    localparam logic [bpeo_pkg::OP_W-1:0] S_CLEAR  = bpeo_pkg::OP_CLEAR;
    localparam logic [bpeo_pkg::OP_W-1:0] S_E_RD   = bpeo_pkg::OP_E_RD;
    localparam logic [bpeo_pkg::OP_W-1:0] S_E_A    = bpeo_pkg::OP_E_A;
    localparam logic [bpeo_pkg::OP_W-1:0] S_E_AW   = bpeo_pkg::OP_E_AW;
    localparam logic [bpeo_pkg::OP_W-1:0] S_E_B    = bpeo_pkg::OP_E_B;
    localparam logic [bpeo_pkg::OP_W-1:0] S_E_BW   = bpeo_pkg::OP_E_BW;
    localparam logic [bpeo_pkg::OP_W-1:0] S_PFX_RD = bpeo_pkg::OP_PFX_RD;
    localparam logic [bpeo_pkg::OP_W-1:0] S_PFX_WR = bpeo_pkg::OP_PFX_WR;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_INIT = bpeo_pkg::OP_W_INIT;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_POP  = bpeo_pkg::OP_W_POP;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_U    = bpeo_pkg::OP_W_U;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_LO   = bpeo_pkg::OP_W_LO;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_HI   = bpeo_pkg::OP_W_HI;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_UC   = bpeo_pkg::OP_W_UC;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_NB   = bpeo_pkg::OP_W_NB;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_V    = bpeo_pkg::OP_W_V;
    localparam logic [bpeo_pkg::OP_W-1:0] S_W_VS   = bpeo_pkg::OP_W_VS;
    localparam logic [bpeo_pkg::OP_W-1:0] S_O_RD   = bpeo_pkg::OP_O_RD;
    localparam logic [bpeo_pkg::OP_W-1:0] S_O_A    = bpeo_pkg::OP_O_A;
    localparam logic [bpeo_pkg::OP_W-1:0] S_O_BIT  = bpeo_pkg::OP_O_BIT;
    localparam logic [bpeo_pkg::OP_W-1:0] S_OUT    = bpeo_pkg::OP_OUT;

    logic [bpeo_pkg::OP_W-1:0] state_reg;
    logic [bpeo_pkg::OP_W-1:0] state_next;
    logic                      fill_reg;
    logic                      fill_next;
    logic                      take;
    logic                      give;

    assign in_tready  = (state_reg == S_LOAD);
    assign out_tvalid = (state_reg == S_OUT);
    assign take       = in_tvalid && in_tready;
    assign give       = out_tvalid && out_tready;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        unique case (state_reg)
            S_LOAD:   state_next = (take && in_last) ? S_CHECK : S_LOAD;
            S_CHECK:
            begin
                fill_next  = 1'b0;
                state_next = stat.err ? S_OUT : S_CLEAR;
            end
            S_CLEAR:  state_next = stat.clr_end ? S_E_RD : S_CLEAR;
            S_E_RD:   state_next = S_E_A;
            S_E_A:    state_next = S_E_AW;
            S_E_AW:   state_next = S_E_B;
            S_E_B:    state_next = S_E_BW;
            S_E_BW:
            begin
                if (stat.ei_last)
                begin
                    state_next = fill_reg ? S_W_INIT : S_PFX_RD;
                end
                else
                begin
                    state_next = S_E_RD;
                end
            end
            S_PFX_RD: state_next = S_PFX_WR;
            S_PFX_WR:
            begin
                if (stat.pfx_end)
                begin
                    fill_next  = 1'b1;
                    state_next = S_E_RD;
                end
                else
                begin
                    state_next = S_PFX_RD;
                end
            end
            S_W_INIT: state_next = S_W_POP;
            S_W_POP:  state_next = stat.sp_zero ? S_O_RD : S_W_U;
            S_W_U:    state_next = S_W_LO;
            S_W_LO:   state_next = S_W_HI;
            S_W_HI:   state_next = S_W_UC;
            S_W_UC:   state_next = S_W_NB;
            S_W_NB:   state_next = stat.k_end ? S_W_POP : S_W_V;
            S_W_V:    state_next = S_W_VS;
            S_W_VS:   state_next = stat.v_clash ? S_OUT : S_W_NB;
            S_O_RD:   state_next = S_O_A;
            S_O_A:    state_next = S_O_BIT;
            S_O_BIT:  state_next = stat.word_end ? S_OUT : S_O_RD;
            S_OUT:
            begin
                if (give)
                begin
                    state_next = stat.out_last ? S_LOAD : S_O_RD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            fill_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    assign cmd.op   = state_reg;
    assign cmd.fill = fill_reg;
    assign cmd.take = take;
    assign cmd.give = give;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_tready && out_tvalid))
        else $error("Input and output handshakes open at once.");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_last |=> state_reg == S_CHECK)
        else $error("Last edge did not start the build.");

    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        give && !stat.out_last |=> state_reg == S_O_RD)
        else $error("Answer ended before its last word.");

    a_clash_reports: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_VS && stat.v_clash |=> out_tvalid && stat.out_last)
        else $error("Odd cycle did not produce a final result.");

endmodule

`default_nettype wire

FILE: hdl/bipartite_edge_orientation.sv
// Top level of the bipartite edge orientation block: joins the controller
// and the datapath. Depends on bpeo_pkg, bpeo_ctrl and bpeo_datapath.
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         tvalid/tready             edge item, tlast = last edge
//   m_axis    out        tvalid/tready             result word, tlast = last word
//   cfg       in         cfg_wen                   node count register
//
// Edges load at one item per cycle. After the last edge, the block builds the
// neighbour lists, walks the graph depth first and then sends the result words;
// all of it is bound by the single read port of each memory. The block takes no
// item from the last edge until the final result word is taken. Reset
// returns to loading with node count 2 and no stored edges.
`default_nettype none

module bipartite_edge_orientation #(
    parameter int MAX_NODES = bpeo_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = bpeo_pkg::DEF_MAX_EDGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_node [10:0], second_node [21:11], zero [23:22]
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // orientation_bits [63:0], bit_count [70:64], zero [71]
    output logic      [71:0] m_axis_tdata,
    // status [1:0]
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast
);

    bpeo_pkg::cmd_t  cmd;
    bpeo_pkg::stat_t stat;

    logic [bpeo_pkg::WORD_BITS-1:0] out_bits;
    logic [bpeo_pkg::BITCNT_W-1:0]  out_count;

    bpeo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_last    (s_axis_tlast),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bpeo_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_first   (s_axis_tdata[10:0]),
        .in_second  (s_axis_tdata[21:11]),
        .out_status (m_axis_tuser),
        .out_bits   (out_bits),
        .out_count  (out_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_count, out_bits};

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for bipartite_edge_orientation: streams edge lists and checks each
// result word against an in-bench two-coloring predictor.
// Depends on bpeo_pkg and the bipartite_edge_orientation RTL.
`default_nettype none

module tb;

    localparam int NODES_MAX = bpeo_pkg::DEF_MAX_NODES;
    localparam int EDGES_MAX = bpeo_pkg::DEF_MAX_EDGES;
    localparam int STALL_LIMIT = 40000;
    localparam int ITEMS_TARGET = 210;

    typedef struct {
        logic [bpeo_pkg::STATUS_W-1:0]  status;
        logic [bpeo_pkg::WORD_BITS-1:0] bits;
        logic [bpeo_pkg::BITCNT_W-1:0]  count;
        logic                           last;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    bipartite_edge_orientation dut (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Coloring predictor state.
    logic [10:0] node_reg = bpeo_pkg::NODE_COUNT_RST;
    int          edge_a [EDGES_MAX];
    int          edge_b [EDGES_MAX];
    int          edges_held = 0;
    bit          bad_edge = 1'b0;
    int          adj_start [NODES_MAX+2];
    int          fill_at [NODES_MAX+2];
    int          adj [2*EDGES_MAX];
    bit          color [NODES_MAX+1];
    bit          seen [NODES_MAX+1];
    int          dfs_stack [NODES_MAX+1];

    answer_t     pending_answers[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    function automatic int node_limit();
        if (node_reg < 1) return 1;
        if (node_reg > NODES_MAX) return NODES_MAX;
        return int'(node_reg);
    endfunction

    function automatic void queue_answer(answer_t r);
        pending_answers = {pending_answers, r};
    endfunction

    function automatic void push_single(logic [bpeo_pkg::STATUS_W-1:0] st);
        answer_t r;
        r.status = st;
        r.bits = '0;
        r.count = '0;
        r.last = 1'b1;
        queue_answer(r);
        edges_held = 0;
        bad_edge = 1'b0;
    endfunction

    function automatic bit two_colorable(int n);
        int sp;
        int u;
        int v;
        for (int i = 0; i <= n + 1; i++) adj_start[i] = 0;
        for (int i = 0; i < edges_held; i++)
        begin
            adj_start[edge_a[i] + 1]++;
            adj_start[edge_b[i] + 1]++;
        end
        for (int i = 1; i <= n + 1; i++) adj_start[i] += adj_start[i-1];
        for (int i = 0; i <= n + 1; i++) fill_at[i] = adj_start[i];
        for (int i = 0; i < edges_held; i++)
        begin
            adj[fill_at[edge_a[i]]++] = edge_b[i];
            adj[fill_at[edge_b[i]]++] = edge_a[i];
        end
        for (int i = 0; i <= NODES_MAX; i++)
        begin
            color[i] = 1'b0;
            seen[i] = 1'b0;
        end
        color[1] = 1'b1;
        seen[1] = 1'b1;
        dfs_stack[0] = 1;
        sp = 1;
        while (sp > 0)
        begin
            sp--;
            u = dfs_stack[sp];
            for (int k = adj_start[u]; k < adj_start[u+1]; k++)
            begin
                v = adj[k];
                if (seen[v])
                begin
                    if (color[v] == color[u]) return 1'b0;
                end
                else
                begin
                    seen[v] = 1'b1;
                    color[v] = ~color[u];
                    dfs_stack[sp++] = v;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_edge(int a, int b, bit last);
        int n;
        int words;
        int cnt;
        answer_t r;
        n = node_limit();
        if (a < 1 || a > n || b < 1 || b > n || edges_held >= EDGES_MAX)
        begin
            bad_edge = 1'b1;
        end
        else
        begin
            edge_a[edges_held] = a;
            edge_b[edges_held] = b;
            edges_held++;
        end
        if (!last) return;
        if (bad_edge)
        begin
            push_single(bpeo_pkg::ST_ERR);
            return;
        end
        if (!two_colorable(n))
        begin
            push_single(bpeo_pkg::ST_ODD);
            return;
        end
        words = (edges_held + bpeo_pkg::WORD_BITS - 1) / bpeo_pkg::WORD_BITS;
        for (int w = 0; w < words; w++)
        begin
            cnt = edges_held - w * bpeo_pkg::WORD_BITS;
            if (cnt > bpeo_pkg::WORD_BITS) cnt = bpeo_pkg::WORD_BITS;
            r.status = bpeo_pkg::ST_OK;
            r.bits = '0;
            for (int k = 0; k < cnt; k++)
                r.bits[k] = color[edge_a[w*bpeo_pkg::WORD_BITS + k]];
            r.count = bpeo_pkg::BITCNT_W'(cnt);
            r.last = (w + 1 == words);
            queue_answer(r);
        end
        edges_held = 0;
        bad_edge = 1'b0;
    endfunction

    task automatic send_edge(int a, int b, bit last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, b[10:0], a[10:0]};
        s_axis_tlast <= last;
        do @(posedge clk); while (!s_axis_tready);
        predict_edge(int'(a[10:0]), int'(b[10:0]), last);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        drain_results();
        cfg_wen <= 1'b1;
        cfg_wdata <= v[10:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        node_reg = v[10:0];
    endtask

    // Receiver stalls with a pattern whose mode is redrawn at random from four modes.
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(10, 60);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ~m_axis_tready;
        endcase
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata[63:0] !== want.bits ||
                    m_axis_tdata[70:64] !== want.count || m_axis_tdata[71] !== 1'b0 ||
                    m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d bits=%h cnt=%0d last=%b, ",
                                  "got st=%0d bits=%h cnt=%0d last=%b"},
                                 want.status, want.bits, want.count, want.last,
                                 m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[70:64],
                                 m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[bipartite_edge_orientation] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_small_graphs();
        send_edge(1, 2, 1);
        send_edge(2, 1, 0);
        send_edge(1, 2, 1);
        send_edge(1, 1, 1);
        send_edge(0, 1, 1);
        send_edge(1, 3, 1);
        send_edge(2047, 2047, 1);
        write_node_count(3);
        send_edge(1, 2, 0);
        send_edge(2, 3, 0);
        send_edge(3, 1, 1);
        send_edge(3, 2, 1);
    endtask

    task automatic test_count_extremes();
        write_node_count(0);
        send_edge(1, 1, 1);
        send_edge(2, 1, 1);
        write_node_count(2047);
        send_edge(1024, 1, 0);
        send_edge(5, 6, 1);
        send_edge(1025, 1, 1);
        write_node_count(1024);
        send_edge(1023, 1024, 0);
        send_edge(1, 1024, 1);
    endtask

    task automatic test_multi_word();
        for (int i = 0; i < 70; i++)
            send_edge(1 + (i % 2), 2 - (i % 2), i == 69);
        drain_results();
    endtask

    task automatic test_random_graphs();
        int kind;
        int n;
        int m;
        int a;
        int b;
        int graphs = 0;
        while (items_sent < ITEMS_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_node_count(1);
                    1: write_node_count(1024);
                    2: write_node_count($urandom_range(0, 2047));
                    default: write_node_count($urandom_range(2, 40));
                endcase
            end
            if (graphs == 5) drain_results();
            n = node_limit();
            kind = $urandom_range(0, 9);
            m = (kind == 9) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            for (int i = 0; i < m; i++)
            begin
                a = $urandom_range(1, n);
                b = $urandom_range(1, n);
                if (kind <= 5 && n >= 2 && (a % 2) == (b % 2)) b = (b == n) ? b - 1 : b + 1;
                if (kind <= 5 && i == 0 && n >= 2) a = 1;
                if (kind == 8 && i == m / 2)
                begin
                    a = $urandom_range(0, 2047);
                    b = $urandom_range(0, 2047);
                end
                send_edge(a, b, i == m - 1);
            end
            graphs++;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_graphs();
        test_count_extremes();
        test_multi_word();
        test_random_graphs();
        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("[bipartite_edge_orientation] OK");
        else
            $display("[bipartite_edge_orientation] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
